### hdl/hrlp_pkg.sv
// ---------------------------------------------------------------------------
// hrlp_pkg: shared types and constants of the HTTP request-line parser
// Queue word layout, parse phases, method and protocol codes, the character
// constants used by the byte classifier and the token text for the parser.
// ---------------------------------------------------------------------------
package hrlp_pkg;

  localparam int URI_W    = 13;
  localparam int METHOD_W = 3;
  localparam int PROTO_W  = 3;

  // Depth of the queue between the classifier and the parser (power of two).
  localparam int QUEUE_DEPTH = 4;

  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_NUL   = 8'h00;

  localparam logic [METHOD_W-1:0] METH_NONE    = 3'd0;
  localparam logic [METHOD_W-1:0] METH_GET     = 3'd1;
  localparam logic [METHOD_W-1:0] METH_POST    = 3'd2;
  localparam logic [METHOD_W-1:0] METH_HEAD    = 3'd3;
  localparam logic [METHOD_W-1:0] METH_OPTIONS = 3'd4;
  localparam logic [METHOD_W-1:0] METH_CONNECT = 3'd5;

  localparam logic [PROTO_W-1:0] PROTO_NONE   = 3'd0;
  localparam logic [PROTO_W-1:0] PROTO_HTTP09 = 3'd1;
  localparam logic [PROTO_W-1:0] PROTO_HTTP10 = 3'd2;
  localparam logic [PROTO_W-1:0] PROTO_HTTP11 = 3'd3;
  localparam logic [PROTO_W-1:0] PROTO_HTTP2  = 3'd4;

  // Token text, first byte in the least significant position.
  localparam logic [23:0] TXT_GET     = 24'h544547;
  localparam logic [31:0] TXT_POST    = 32'h54534F50;
  localparam logic [31:0] TXT_HEAD    = 32'h44414548;
  localparam logic [55:0] TXT_OPTIONS = 56'h534E4F4954504F;
  localparam logic [55:0] TXT_CONNECT = 56'h5443454E4E4F43;
  localparam logic [63:0] TXT_HTTP11  = 64'h312E312F50545448;
  localparam logic [63:0] TXT_HTTP10  = 64'h302E312F50545448;
  localparam logic [63:0] TXT_HTTP09  = 64'h392E302F50545448;
  localparam logic [47:0] TXT_HTTP2   = 48'h322F50545448;

  typedef enum logic [2:0] {
    PH_METHOD,
    PH_URI_FIRST,
    PH_URI,
    PH_VER_FIRST,
    PH_VER,
    PH_GOOD,
    PH_BAD
  } hrlp_phase_t;

  // One classified byte as it travels through the queue.
  typedef struct packed {
    logic [7:0] line_byte;
    logic       final_byte;
    logic       is_space;
    logic       is_cr;
    logic       is_lf;
    logic       is_nul;
  } hrlp_item_t;

  typedef struct packed {
    logic empty;
    logic full;
  } hrlp_q_stat_t;

endpackage

### hdl/hrlp_front.sv
// ---------------------------------------------------------------------------
// hrlp_front: input stage of the request-line parser
// Accepts bytes from the input channel and tags each one with its
// character class before it enters the queue.
// ---------------------------------------------------------------------------
module hrlp_front (
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          in_line_byte,
  input  logic                in_final_byte,
  input  hrlp_pkg::hrlp_q_stat_t q_stat,
  output logic                push,
  output hrlp_pkg::hrlp_item_t push_item
);

  assign in_ready = !q_stat.full;
  assign push     = in_valid && !q_stat.full;

  always_comb begin
    push_item.line_byte  = in_line_byte;
    push_item.final_byte = in_final_byte;
    push_item.is_space   = (in_line_byte == hrlp_pkg::CHAR_SPACE);
    push_item.is_cr      = (in_line_byte == hrlp_pkg::CHAR_CR);
    push_item.is_lf      = (in_line_byte == hrlp_pkg::CHAR_LF);
    push_item.is_nul     = (in_line_byte == hrlp_pkg::CHAR_NUL);
  end

endmodule

### hdl/hrlp_queue.sv
// ---------------------------------------------------------------------------
// hrlp_queue: short queue between classifier and parser
// A small register queue of classified bytes so that each side can stall
// on its own.
// ---------------------------------------------------------------------------
module hrlp_queue (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  hrlp_pkg::hrlp_item_t   push_item,
  input  logic                   pop,
  output hrlp_pkg::hrlp_item_t   head_item,
  output hrlp_pkg::hrlp_q_stat_t q_stat
);

  localparam int AW = $clog2(hrlp_pkg::QUEUE_DEPTH);

  hrlp_pkg::hrlp_item_t entries_r [hrlp_pkg::QUEUE_DEPTH];
  logic [AW-1:0] wr_ptr_r;
  logic [AW-1:0] rd_ptr_r;
  logic [AW:0]   count_r;

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  assign head_item    = entries_r[rd_ptr_r];
  assign q_stat.empty = (count_r == '0);
  assign q_stat.full  = (count_r == (AW+1)'(hrlp_pkg::QUEUE_DEPTH));

endmodule

### hdl/hrlp_parser.sv
// ---------------------------------------------------------------------------
// hrlp_parser: phase machine of the request-line parser
// Takes one classified byte per cycle while the queue has one, tracks method,
// URI and version, and loads the result register on the final byte once free.
// ---------------------------------------------------------------------------
module hrlp_parser #(
  parameter int LINE_BYTES  = 8192,
  parameter int TOKEN_BYTES = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  hrlp_pkg::hrlp_item_t            head_item,
  input  hrlp_pkg::hrlp_q_stat_t          q_stat,
  output logic                            pop,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_status,
  output logic [hrlp_pkg::METHOD_W-1:0]   out_method_code,
  output logic [hrlp_pkg::PROTO_W-1:0]    out_protocol_code,
  output logic [hrlp_pkg::URI_W-1:0]      out_uri_offset,
  output logic [hrlp_pkg::URI_W-1:0]      out_uri_length
);

  localparam int PW = $clog2(LINE_BYTES + 1);
  localparam int CW = $clog2(TOKEN_BYTES + 1);

  function automatic logic [hrlp_pkg::METHOD_W-1:0] method_lookup(
    input logic [63:0] p,
    input logic        ge3,
    input logic        ge4,
    input logic        ge7
  );
    logic [hrlp_pkg::METHOD_W-1:0] code;
    code = hrlp_pkg::METH_NONE;
    priority if (ge3 && p[23:0] == hrlp_pkg::TXT_GET) begin
      code = hrlp_pkg::METH_GET;
    end else if (ge4 && p[31:0] == hrlp_pkg::TXT_POST) begin
      code = hrlp_pkg::METH_POST;
    end else if (ge4 && p[31:0] == hrlp_pkg::TXT_HEAD) begin
      code = hrlp_pkg::METH_HEAD;
    end else if (ge7 && p[55:0] == hrlp_pkg::TXT_OPTIONS) begin
      code = hrlp_pkg::METH_OPTIONS;
    end else if (ge7 && p[55:0] == hrlp_pkg::TXT_CONNECT) begin
      code = hrlp_pkg::METH_CONNECT;
    end else begin
      code = hrlp_pkg::METH_NONE;
    end
    return code;
  endfunction

  function automatic logic [hrlp_pkg::PROTO_W-1:0] version_lookup(
    input logic [63:0] p,
    input logic        ge6,
    input logic        ge8
  );
    logic [hrlp_pkg::PROTO_W-1:0] code;
    code = hrlp_pkg::PROTO_NONE;
    priority if (ge8 && p == hrlp_pkg::TXT_HTTP11) begin
      code = hrlp_pkg::PROTO_HTTP11;
    end else if (ge8 && p == hrlp_pkg::TXT_HTTP10) begin
      code = hrlp_pkg::PROTO_HTTP10;
    end else if (ge8 && p == hrlp_pkg::TXT_HTTP09) begin
      code = hrlp_pkg::PROTO_HTTP09;
    end else if (ge6 && p[47:0] == hrlp_pkg::TXT_HTTP2) begin
      code = hrlp_pkg::PROTO_HTTP2;
    end else begin
      code = hrlp_pkg::PROTO_NONE;
    end
    return code;
  endfunction

  hrlp_pkg::hrlp_phase_t phase_r, phase_nxt, phase_mid, phase_take;

  logic [63:0]                   prefix_r, prefix_nxt, prefix_take;
  logic [CW-1:0]                 count_r, count_nxt, count_take;
  logic [PW-1:0]                 pos_r, pos_nxt;
  logic [PW-1:0]                 begin_r, begin_nxt, begin_take;
  logic [PW-1:0]                 span_r, span_nxt, span_take;
  logic [hrlp_pkg::METHOD_W-1:0] method_r, method_nxt, method_take;
  logic [hrlp_pkg::PROTO_W-1:0]  proto_r, proto_nxt, proto_take;

  logic                          out_valid_r;
  logic                          out_status_r;
  logic [hrlp_pkg::METHOD_W-1:0] out_method_r;
  logic [hrlp_pkg::PROTO_W-1:0]  out_proto_r;
  logic [hrlp_pkg::URI_W-1:0]    out_offset_r;
  logic [hrlp_pkg::URI_W-1:0]    out_length_r;

  logic                          is_delim;
  logic                          pending;
  logic                          pos_over;
  logic [63:0]                   base_prefix, push_prefix, dec_prefix;
  logic [CW-1:0]                 base_count, push_count, dec_count;
  logic                          long_tok;
  logic [hrlp_pkg::METHOD_W-1:0] meth_code;
  logic [hrlp_pkg::PROTO_W-1:0]  ver_code;
  logic                          ver_hit;
  logic                          res_good;
  logic [31:0]                   begin_ext, span_ext;

  assign pop = !q_stat.empty && (!head_item.final_byte || !out_valid_r || out_ready);

  assign is_delim = head_item.is_space || head_item.is_cr || head_item.is_lf;
  assign pending  = (phase_r != hrlp_pkg::PH_GOOD) && (phase_r != hrlp_pkg::PH_BAD);
  assign pos_over = (pos_r >= PW'(LINE_BYTES));

  // A version token starts from an empty buffer; a method token grows in place.
  assign base_prefix = (phase_r == hrlp_pkg::PH_VER_FIRST) ? '0 : prefix_r;
  assign base_count  = (phase_r == hrlp_pkg::PH_VER_FIRST) ? '0 : count_r;
  assign push_count  = base_count + 1'b1;
  assign long_tok    = (push_count >= CW'(TOKEN_BYTES));

  always_comb begin
    push_prefix = base_prefix;
    for (int i = 0; i < 8; i++) begin
      if (base_count == CW'(i)) begin
        push_prefix[8*i +: 8] = head_item.line_byte;
      end
    end
  end

  // The version is judged on the token as it stands after this byte.
  assign dec_prefix = is_delim ? prefix_r : push_prefix;
  assign dec_count  = is_delim ? count_r : push_count;

  assign meth_code = method_lookup(prefix_r, count_r >= CW'(3), count_r >= CW'(4),
                                   count_r >= CW'(7));
  assign ver_code  = version_lookup(dec_prefix, dec_count >= CW'(6), dec_count >= CW'(8));
  assign ver_hit   = (ver_code != hrlp_pkg::PROTO_NONE);

  // Next phase.
  always_comb begin
    phase_mid = phase_r;
    if (pending) begin
      if (pos_over) begin
        phase_mid = hrlp_pkg::PH_BAD;
      end else begin
        unique case (phase_r)
          hrlp_pkg::PH_METHOD: begin
            if (is_delim) begin
              phase_mid = (meth_code == hrlp_pkg::METH_NONE) ? hrlp_pkg::PH_BAD
                                                             : hrlp_pkg::PH_URI_FIRST;
            end else if (long_tok) begin
              phase_mid = hrlp_pkg::PH_BAD;
            end
          end
          hrlp_pkg::PH_URI_FIRST: begin
            phase_mid = (is_delim || head_item.is_nul) ? hrlp_pkg::PH_BAD
                                                       : hrlp_pkg::PH_URI;
          end
          hrlp_pkg::PH_URI: begin
            if (head_item.is_cr) begin
              phase_mid = hrlp_pkg::PH_GOOD;
            end else if (head_item.is_space) begin
              phase_mid = hrlp_pkg::PH_VER_FIRST;
            end else if (head_item.is_lf || head_item.is_nul) begin
              phase_mid = hrlp_pkg::PH_BAD;
            end
          end
          hrlp_pkg::PH_VER_FIRST: begin
            if (is_delim || long_tok) begin
              phase_mid = hrlp_pkg::PH_BAD;
            end else begin
              phase_mid = hrlp_pkg::PH_VER;
            end
          end
          hrlp_pkg::PH_VER: begin
            if (is_delim) begin
              phase_mid = ver_hit ? hrlp_pkg::PH_GOOD : hrlp_pkg::PH_BAD;
            end else if (long_tok) begin
              phase_mid = hrlp_pkg::PH_BAD;
            end
          end
          default: begin
            phase_mid = phase_r;
          end
        endcase
      end
    end

    // The final byte forces a decision on whatever is still open.
    phase_take = phase_mid;
    if (head_item.final_byte && phase_mid != hrlp_pkg::PH_GOOD
        && phase_mid != hrlp_pkg::PH_BAD) begin
      phase_take = (phase_mid == hrlp_pkg::PH_VER && ver_hit) ? hrlp_pkg::PH_GOOD
                                                             : hrlp_pkg::PH_BAD;
    end

    if (!pop) begin
      phase_nxt = phase_r;
    end else if (head_item.final_byte) begin
      phase_nxt = hrlp_pkg::PH_METHOD;
    end else begin
      phase_nxt = phase_take;
    end
  end

  // Token buffer, URI span and codes.
  always_comb begin
    prefix_take = prefix_r;
    count_take  = count_r;
    begin_take  = begin_r;
    span_take   = span_r;
    method_take = method_r;
    proto_take  = proto_r;
    if (pending && !pos_over) begin
      unique case (phase_r)
        hrlp_pkg::PH_METHOD: begin
          if (is_delim) begin
            prefix_take = '0;
            count_take  = '0;
            method_take = meth_code;
          end else begin
            prefix_take = push_prefix;
            count_take  = push_count;
          end
        end
        hrlp_pkg::PH_URI_FIRST: begin
          begin_take = pos_r;
        end
        hrlp_pkg::PH_URI: begin
          if (head_item.is_cr || head_item.is_space) begin
            span_take = pos_r - begin_r;
          end
          if (head_item.is_cr) begin
            proto_take = hrlp_pkg::PROTO_HTTP09;
          end
        end
        hrlp_pkg::PH_VER_FIRST, hrlp_pkg::PH_VER: begin
          if (is_delim) begin
            if (phase_r == hrlp_pkg::PH_VER) begin
              proto_take = ver_hit ? ver_code : hrlp_pkg::PROTO_HTTP11;
            end
          end else begin
            prefix_take = push_prefix;
            count_take  = push_count;
            if (long_tok) begin
              proto_take = hrlp_pkg::PROTO_HTTP11;
            end
          end
        end
        default: begin
          prefix_take = prefix_r;
        end
      endcase
    end
    if (head_item.final_byte && phase_mid == hrlp_pkg::PH_VER) begin
      proto_take = ver_hit ? ver_code : hrlp_pkg::PROTO_HTTP11;
    end

    pos_nxt    = pos_r;
    prefix_nxt = prefix_r;
    count_nxt  = count_r;
    begin_nxt  = begin_r;
    span_nxt   = span_r;
    method_nxt = method_r;
    proto_nxt  = proto_r;
    if (pop) begin
      if (head_item.final_byte) begin
        pos_nxt    = '0;
        prefix_nxt = '0;
        count_nxt  = '0;
        begin_nxt  = '0;
        span_nxt   = '0;
        method_nxt = hrlp_pkg::METH_NONE;
        proto_nxt  = hrlp_pkg::PROTO_NONE;
      end else begin
        pos_nxt    = pos_over ? pos_r : pos_r + 1'b1;
        prefix_nxt = prefix_take;
        count_nxt  = count_take;
        begin_nxt  = begin_take;
        span_nxt   = span_take;
        method_nxt = method_take;
        proto_nxt  = proto_take;
      end
    end
  end

  assign res_good  = (phase_take == hrlp_pkg::PH_GOOD);
  assign begin_ext = 32'(begin_take);
  assign span_ext  = 32'(span_take);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= hrlp_pkg::PH_METHOD;
      prefix_r    <= '0;
      count_r     <= '0;
      pos_r       <= '0;
      begin_r     <= '0;
      span_r      <= '0;
      method_r    <= hrlp_pkg::METH_NONE;
      proto_r     <= hrlp_pkg::PROTO_NONE;
      out_valid_r <= 1'b0;
    end else begin
      phase_r  <= phase_nxt;
      prefix_r <= prefix_nxt;
      count_r  <= count_nxt;
      pos_r    <= pos_nxt;
      begin_r  <= begin_nxt;
      span_r   <= span_nxt;
      method_r <= method_nxt;
      proto_r  <= proto_nxt;
      if (pop && head_item.final_byte) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && head_item.final_byte) begin
      out_status_r <= !res_good;
      out_method_r <= method_take;
      out_proto_r  <= proto_take;
      out_offset_r <= res_good ? begin_ext[hrlp_pkg::URI_W-1:0] : '0;
      out_length_r <= res_good ? span_ext[hrlp_pkg::URI_W-1:0] : '0;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_method_code   = out_method_r;
  assign out_protocol_code = out_proto_r;
  assign out_uri_offset    = out_offset_r;
  assign out_uri_length    = out_length_r;

`ifndef SYNTH
  a_good_has_codes: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_status_r ||
                     (out_method_r != hrlp_pkg::METH_NONE &&
                      out_proto_r != hrlp_pkg::PROTO_NONE)))
    else $error("good result without method or protocol");

  a_pos_saturates: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= PW'(LINE_BYTES))
    else $error("byte position beyond line limit");

  a_final_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && head_item.final_byte) |=>
      (out_valid_r && phase_r == hrlp_pkg::PH_METHOD && pos_r == '0))
    else $error("final byte did not produce a result and restart");

  a_uri_needs_method: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == hrlp_pkg::PH_URI_FIRST || phase_r == hrlp_pkg::PH_URI ||
     phase_r == hrlp_pkg::PH_VER_FIRST || phase_r == hrlp_pkg::PH_VER) |->
      (method_r != hrlp_pkg::METH_NONE))
    else $error("URI or version phase without a known method");
`endif

endmodule

### hdl/http_request_line_parser.sv
// ---------------------------------------------------------------------------
// http_request_line_parser: streaming HTTP request-line parser
// Splits a request line into method, URI and version and reports one
// result word per line.
// ---------------------------------------------------------------------------
// Usage:
// The input channel carries one byte of the request line per word, with
// in_final_byte set on the last byte of the buffer. The output channel
// carries one result word per line: status, method code, protocol code and
// the URI offset and length (both zero for a bad request).
// Throughput is one byte per cycle: the parser phase machine takes one byte
// from the queue in each cycle that the queue holds one, save the final-byte
// wait below. out_valid is registered: it rises in the cycle after the parser
// takes the final byte. The classifier and parser are split by a four-word
// queue; the result sits in an output register, so bytes of the next line
// keep flowing while a result waits. Only a final byte that meets a full
// output register waits; in_ready then drops once the queue fills.
// Reset (rst_n low, synchronous) empties the queue, drops out_valid and puts
// the parser back to expecting a method.
// ---------------------------------------------------------------------------
module http_request_line_parser #(
  parameter int LINE_BYTES  = 8192,
  parameter int TOKEN_BYTES = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [7:0]                    in_line_byte,
  input  logic                          in_final_byte,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_status,
  output logic [hrlp_pkg::METHOD_W-1:0] out_method_code,
  output logic [hrlp_pkg::PROTO_W-1:0]  out_protocol_code,
  output logic [hrlp_pkg::URI_W-1:0]    out_uri_offset,
  output logic [hrlp_pkg::URI_W-1:0]    out_uri_length
);

  hrlp_pkg::hrlp_item_t   push_item;
  hrlp_pkg::hrlp_item_t   head_item;
  hrlp_pkg::hrlp_q_stat_t q_stat;
  logic                   push;
  logic                   pop;

  hrlp_front u_front (
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_line_byte  (in_line_byte),
    .in_final_byte (in_final_byte),
    .q_stat        (q_stat),
    .push          (push),
    .push_item     (push_item)
  );

  hrlp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head_item (head_item),
    .q_stat    (q_stat)
  );

  hrlp_parser #(
    .LINE_BYTES  (LINE_BYTES),
    .TOKEN_BYTES (TOKEN_BYTES)
  ) u_parser (
    .clk               (clk),
    .rst_n             (rst_n),
    .head_item         (head_item),
    .q_stat            (q_stat),
    .pop               (pop),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_method_code   (out_method_code),
    .out_protocol_code (out_protocol_code),
    .out_uri_offset    (out_uri_offset),
    .out_uri_length    (out_uri_length)
  );

endmodule
